@@ design/quic_transport_param_decoder_macros.svh @@
// Assertion macros shared by the transport parameter decoder modules.
// No dependencies; included by the files that carry assertions.
`ifndef QUIC_TRANSPORT_PARAM_DECODER_MACROS_SVH
`define QUIC_TRANSPORT_PARAM_DECODER_MACROS_SVH

// Property holds in the same cycle as its trigger.
`define QTPD_ASSERT_SAME(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error(msg);

// Property holds in the cycle after its trigger.
`define QTPD_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

@@ design/qtpd_pkg.sv @@
// Types and constants for the QUIC transport parameter decoder.
// No dependencies.
package qtpd_pkg;

   typedef struct packed {
      logic [7:0] list_byte;
      logic       byte_present;
      logic       end_of_list;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [4:0]  param_id;
      logic [61:0] int_value;
      logic [7:0]  blob_byte;
      logic [4:0]  blob_index;
      logic [3:0]  status;
      logic        run_last;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_ID   = 2'd0,
      PH_LEN  = 2'd1,
      PH_VAL  = 2'd2,
      PH_HALT = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [61:0] accum;
      logic [2:0]  left;
      logic [4:0]  current_id;
      logic        id_unknown;
      logic [16:0] seen;
      logic [3:0]  sticky;
      logic [7:0]  pref_cid;
   } state_type;

   localparam int RES_SLOTS = 3;

   localparam logic [1:0] KIND_INT     = 2'd0;
   localparam logic [1:0] KIND_BLOB    = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;
   localparam logic [1:0] KIND_VERDICT = 2'd3;

   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_TRUNCATED   = 4'd1;
   localparam logic [3:0] ST_DUPLICATE   = 4'd2;
   localparam logic [3:0] ST_CLIENT_BAN  = 4'd3;
   localparam logic [3:0] ST_CID_LEN     = 4'd4;
   localparam logic [3:0] ST_TOKEN_LEN   = 4'd5;
   localparam logic [3:0] ST_FLAG_LEN    = 4'd6;
   localparam logic [3:0] ST_PREF_ADDR   = 4'd7;
   localparam logic [3:0] ST_INT_FILL    = 4'd8;
   localparam logic [3:0] ST_RANGE       = 4'd9;
   localparam logic [3:0] ST_NO_INIT_SCID = 4'd10;
   localparam logic [3:0] ST_NO_ORIG_DCID = 4'd11;

   localparam logic [4:0] ID_ORIG_DCID   = 5'd0;
   localparam logic [4:0] ID_RESET_TOKEN = 5'd2;
   localparam logic [4:0] ID_MAX_UDP     = 5'd3;
   localparam logic [4:0] ID_STREAMS_BIDI = 5'd8;
   localparam logic [4:0] ID_STREAMS_UNI = 5'd9;
   localparam logic [4:0] ID_ACK_EXP     = 5'd10;
   localparam logic [4:0] ID_ACK_DELAY   = 5'd11;
   localparam logic [4:0] ID_NO_MIGRATE  = 5'd12;
   localparam logic [4:0] ID_PREF_ADDR   = 5'd13;
   localparam logic [4:0] ID_CID_LIMIT   = 5'd14;
   localparam logic [4:0] ID_INIT_SCID   = 5'd15;
   localparam logic [4:0] ID_RETRY_SCID  = 5'd16;
   localparam logic [61:0] ID_LAST_KNOWN = 62'd16;

   localparam logic [63:0] MAX_CID_BYTES  = 64'd20;
   localparam logic [63:0] TOKEN_BYTES    = 64'd16;
   localparam logic [63:0] PREF_FIXED     = 64'd25;
   localparam logic [63:0] PREF_CID_POS   = 64'd24;
   localparam logic [61:0] UDP_MIN        = 62'd1200;
   localparam logic [61:0] ACK_EXP_MAX    = 62'd20;
   localparam logic [61:0] ACK_DELAY_LIMIT = 62'd16384;
   localparam logic [61:0] STREAMS_MAX    = 62'h1000_0000_0000_0000;
   localparam logic [61:0] CID_LIMIT_MIN  = 62'd2;

endpackage

@@ design/qtpd_step.sv @@
// Per-beat decode: varint assembly, parameter checks and result building.
// Depends on qtpd_pkg.
module qtpd_step #(
   parameter int LENGTH_BITS = 16
) (
   input  qtpd_pkg::state_type          st,
   input  logic [LENGTH_BITS-1:0]       len_cur,
   input  logic [LENGTH_BITS-1:0]       seen_cur,
   input  qtpd_pkg::req_type            item,
   input  logic                         peer_is_server,
   output qtpd_pkg::state_type          st_next,
   output logic [LENGTH_BITS-1:0]       len_next,
   output logic [LENGTH_BITS-1:0]       seen_next,
   output qtpd_pkg::rsp_type            res [qtpd_pkg::RES_SLOTS],
   output logic [1:0]                   res_count
);

   always_comb begin
      logic [7:0]             b;
      logic [61:0]            acc_n;
      logic [2:0]             left_n;
      logic [LENGTH_BITS:0]   idx1;
      logic [63:0]            len64;
      logic [63:0]            idx64;
      logic                   do_complete;
      logic                   unk;
      logic [4:0]             cid;
      logic                   is_cid;
      logic [61:0]            v;
      logic                   blob_v;
      logic                   done_v;
      qtpd_pkg::rsp_type      blob_r;
      qtpd_pkg::rsp_type      done_r;
      qtpd_pkg::rsp_type      ver_r;
      logic [3:0]             vst;
      logic [1:0]             n;

      b           = item.list_byte;
      st_next     = st;
      len_next    = len_cur;
      seen_next   = seen_cur;
      acc_n       = '0;
      left_n      = '0;
      idx1        = '0;
      len64       = '0;
      cid         = '0;
      is_cid      = 1'b0;
      do_complete = 1'b0;
      unk         = 1'b0;
      blob_v      = 1'b0;
      done_v      = 1'b0;
      blob_r      = '0;
      done_r      = '0;
      ver_r       = '0;
      vst         = qtpd_pkg::ST_OK;
      v           = '0;
      idx64       = 64'(seen_cur);

      if (item.byte_present && st.phase != qtpd_pkg::PH_HALT) begin
         case (st.phase)
            qtpd_pkg::PH_ID, qtpd_pkg::PH_LEN: begin
               if (st.left == 3'd0) begin
                  acc_n  = {56'd0, b[5:0]};
                  left_n = {b[7] & b[6], b[7], b[7] | b[6]};
               end else begin
                  acc_n  = {st.accum[53:0], b};
                  left_n = st.left - 3'd1;
               end
               st_next.accum = acc_n;
               st_next.left  = left_n;
               if (left_n == 3'd0) begin
                  if (st.phase == qtpd_pkg::PH_ID) begin
                     unk                = acc_n > qtpd_pkg::ID_LAST_KNOWN;
                     st_next.id_unknown = unk;
                     st_next.current_id = unk ? 5'd0 : acc_n[4:0];
                     st_next.phase      = qtpd_pkg::PH_LEN;
                  end else if ((acc_n >> LENGTH_BITS) != 62'd0) begin
                     st_next.sticky = qtpd_pkg::ST_TRUNCATED;
                     st_next.phase  = qtpd_pkg::PH_HALT;
                  end else begin
                     len_next         = acc_n[LENGTH_BITS-1:0];
                     seen_next        = '0;
                     st_next.accum    = '0;
                     st_next.pref_cid = '0;
                     if (acc_n == 62'd0) begin
                        do_complete = 1'b1;
                     end else begin
                        st_next.phase = qtpd_pkg::PH_VAL;
                     end
                  end
               end
            end
            qtpd_pkg::PH_VAL: begin
               len64  = 64'(len_cur);
               cid    = st.current_id;
               is_cid = cid == qtpd_pkg::ID_ORIG_DCID || cid == qtpd_pkg::ID_INIT_SCID ||
                        cid == qtpd_pkg::ID_RETRY_SCID;
               blob_r.result_kind = qtpd_pkg::KIND_BLOB;
               blob_r.param_id    = cid;
               blob_r.blob_byte   = b;
               blob_r.blob_index  = seen_cur[4:0];
               if (!st.id_unknown) begin
                  if (is_cid) begin
                     blob_v = len64 <= qtpd_pkg::MAX_CID_BYTES;
                  end else if (cid == qtpd_pkg::ID_RESET_TOKEN) begin
                     blob_v = len64 == qtpd_pkg::TOKEN_BYTES;
                  end else if (cid == qtpd_pkg::ID_PREF_ADDR) begin
                     if (idx64 == qtpd_pkg::PREF_CID_POS) begin
                        st_next.pref_cid = b;
                     end
                  end else if (cid != qtpd_pkg::ID_NO_MIGRATE) begin
                     if (idx64 == 64'd0) begin
                        st_next.left  = {1'b0, b[7:6]};
                        st_next.accum = {56'd0, b[5:0]};
                     end else if (idx64 < (64'd1 << st.left[1:0])) begin
                        st_next.accum = {st.accum[53:0], b};
                     end
                  end
               end
               idx1      = {1'b0, seen_cur} + {{LENGTH_BITS{1'b0}}, 1'b1};
               seen_next = idx1[LENGTH_BITS-1:0];
               if (idx1 == {1'b0, len_cur}) begin
                  do_complete = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // parameter close-out, on the state as updated by this beat
      if (do_complete) begin
         cid    = st_next.current_id;
         len64  = 64'(len_next);
         is_cid = cid == qtpd_pkg::ID_ORIG_DCID || cid == qtpd_pkg::ID_INIT_SCID ||
                  cid == qtpd_pkg::ID_RETRY_SCID;
         v      = st_next.accum;
         st_next.phase = qtpd_pkg::PH_ID;
         done_r.param_id    = cid;
         done_r.result_kind = qtpd_pkg::KIND_DONE;
         done_r.int_value   = 62'(len_next);
         if (st_next.id_unknown) begin
            st_next.left = '0;
         end else if (st_next.seen[cid]) begin
            st_next.sticky = qtpd_pkg::ST_DUPLICATE;
         end else begin
            st_next.seen[cid] = 1'b1;
            if (!peer_is_server && (cid == qtpd_pkg::ID_ORIG_DCID ||
                  cid == qtpd_pkg::ID_RETRY_SCID || cid == qtpd_pkg::ID_RESET_TOKEN ||
                  cid == qtpd_pkg::ID_PREF_ADDR)) begin
               st_next.sticky = qtpd_pkg::ST_CLIENT_BAN;
            end else if (is_cid) begin
               if (len64 > qtpd_pkg::MAX_CID_BYTES) begin
                  st_next.sticky = qtpd_pkg::ST_CID_LEN;
               end
            end else if (cid == qtpd_pkg::ID_RESET_TOKEN) begin
               if (len64 != qtpd_pkg::TOKEN_BYTES) begin
                  st_next.sticky = qtpd_pkg::ST_TOKEN_LEN;
               end
            end else if (cid == qtpd_pkg::ID_NO_MIGRATE) begin
               if (len64 != 64'd0) begin
                  st_next.sticky = qtpd_pkg::ST_FLAG_LEN;
               end
            end else if (cid == qtpd_pkg::ID_PREF_ADDR) begin
               if (len64 < qtpd_pkg::PREF_FIXED ||
                   len64 != qtpd_pkg::PREF_FIXED + 64'(st_next.pref_cid) +
                            qtpd_pkg::TOKEN_BYTES ||
                   64'(st_next.pref_cid) > qtpd_pkg::MAX_CID_BYTES) begin
                  st_next.sticky = qtpd_pkg::ST_PREF_ADDR;
               end
            end else begin
               done_r.result_kind = qtpd_pkg::KIND_INT;
               done_r.int_value   = v;
               if (len64 == 64'd0 || len64 != (64'd1 << st_next.left[1:0])) begin
                  st_next.sticky = qtpd_pkg::ST_INT_FILL;
               end else if ((cid == qtpd_pkg::ID_MAX_UDP && v < qtpd_pkg::UDP_MIN) ||
                     ((cid == qtpd_pkg::ID_STREAMS_BIDI || cid == qtpd_pkg::ID_STREAMS_UNI)
                        && v > qtpd_pkg::STREAMS_MAX) ||
                     (cid == qtpd_pkg::ID_ACK_EXP && v > qtpd_pkg::ACK_EXP_MAX) ||
                     (cid == qtpd_pkg::ID_ACK_DELAY && v >= qtpd_pkg::ACK_DELAY_LIMIT) ||
                     (cid == qtpd_pkg::ID_CID_LIMIT && v < qtpd_pkg::CID_LIMIT_MIN)) begin
                  st_next.sticky = qtpd_pkg::ST_RANGE;
               end
            end
            if (st_next.sticky == qtpd_pkg::ST_OK) begin
               done_v       = 1'b1;
               st_next.left = '0;
            end
         end
         if (st_next.sticky != qtpd_pkg::ST_OK) begin
            st_next.phase = qtpd_pkg::PH_HALT;
         end
      end

      // list close: verdict, then back to a clean list
      if (item.end_of_list) begin
         if (st_next.sticky != qtpd_pkg::ST_OK) begin
            vst = st_next.sticky;
         end else if (st_next.phase != qtpd_pkg::PH_ID || st_next.left != 3'd0) begin
            vst = qtpd_pkg::ST_TRUNCATED;
         end else if (!st_next.seen[qtpd_pkg::ID_INIT_SCID]) begin
            vst = qtpd_pkg::ST_NO_INIT_SCID;
         end else if (peer_is_server && !st_next.seen[qtpd_pkg::ID_ORIG_DCID]) begin
            vst = qtpd_pkg::ST_NO_ORIG_DCID;
         end
         ver_r.result_kind = qtpd_pkg::KIND_VERDICT;
         ver_r.status      = vst;
         ver_r.run_last    = 1'b1;
         st_next       = '0;
         st_next.phase = qtpd_pkg::PH_ID;
         len_next      = '0;
         seen_next     = '0;
      end

      for (int i = 0; i < qtpd_pkg::RES_SLOTS; i++) begin
         res[i] = '0;
      end
      n = 2'd0;
      if (blob_v) begin
         res[n] = blob_r;
         n      = n + 2'd1;
      end
      if (done_v) begin
         res[n] = done_r;
         n      = n + 2'd1;
      end
      if (item.end_of_list) begin
         res[n] = ver_r;
         n      = n + 2'd1;
      end
      res_count = n;
   end

endmodule

@@ design/qtpd_outbuf.sv @@
// Three-entry result buffer: loads a beat's results, drains one a cycle if ready.
// Depends on qtpd_pkg and the decoder macro header.
`include "quic_transport_param_decoder_macros.svh"

module qtpd_outbuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [1:0]        load_count,
   input  qtpd_pkg::rsp_type load_items [qtpd_pkg::RES_SLOTS],
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qtpd_pkg::rsp_type rsp_item
);

   qtpd_pkg::rsp_type buf_ff [qtpd_pkg::RES_SLOTS];
   qtpd_pkg::rsp_type buf_in [qtpd_pkg::RES_SLOTS];
   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;
   logic              pop;

   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_item  = buf_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   // room for a whole beat once the last waiting result leaves
   assign space     = cnt_ff == 2'd0 || (cnt_ff == 2'd1 && rsp_ready);

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (load) begin
         buf_in = load_items;
         cnt_in = load_count;
      end else if (pop) begin
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
         cnt_in    = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `QTPD_ASSERT_SAME(a_load_when_room, clock, reset, load, cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop), "load over waiting results")
   `QTPD_ASSERT_NEXT(a_load_count, clock, reset, load, cnt_ff == $past(load_count), "buffer count after load")
   `QTPD_ASSERT_NEXT(a_drain, clock, reset, pop && !load, cnt_ff == $past(cnt_ff) - 2'd1, "buffer count after drain")

endmodule

@@ design/quic_transport_param_decoder.sv @@
// QUIC transport parameter list decoder, one list byte per beat.
// Depends on qtpd_pkg, qtpd_step, qtpd_outbuf and the decoder macro header.
//
// Each accepted beat is decoded in the cycle it is taken: its results (at most a blob
// byte, a parameter result and the verdict, in that order) are loaded together into a
// three-entry output buffer that hands them out one per cycle while rsp_ready is high. A
// beat is taken whenever that buffer is empty or its last entry leaves in the same cycle,
// so the block runs at one beat per cycle while rsp_ready is high and each beat yields at
// most one result; more results stall the input. Write csr_peer_is_server only between lists.
`include "quic_transport_param_decoder_macros.svh"

module quic_transport_param_decoder #(
   parameter int LENGTH_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qtpd_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qtpd_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_peer_is_server
);

   qtpd_pkg::state_type      state_ff;
   qtpd_pkg::state_type      state_in;
   logic [LENGTH_BITS-1:0]   len_ff;
   logic [LENGTH_BITS-1:0]   len_in;
   logic [LENGTH_BITS-1:0]   seen_ff;
   logic [LENGTH_BITS-1:0]   seen_in;
   logic                     server_ff;
   qtpd_pkg::rsp_type        res [qtpd_pkg::RES_SLOTS];
   logic [1:0]               res_count;
   logic                     take;

   assign csr_ready = 1'b1;
   assign take      = req_valid && req_ready;

   qtpd_step #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_step (
      .st             (state_ff),
      .len_cur        (len_ff),
      .seen_cur       (seen_ff),
      .item           (req_item),
      .peer_is_server (server_ff),
      .st_next        (state_in),
      .len_next       (len_in),
      .seen_next      (seen_in),
      .res            (res),
      .res_count      (res_count)
   );

   qtpd_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .load_count (res_count),
      .load_items (res),
      .space      (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

   // all-zero state is the reading-id phase
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         len_ff    <= '0;
         seen_ff   <= '0;
         server_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff <= state_in;
            len_ff   <= len_in;
            seen_ff  <= seen_in;
         end
         if (csr_valid && csr_ready) begin
            server_ff <= csr_peer_is_server;
         end
      end
   end

   `QTPD_ASSERT_SAME(a_error_halts, clock, reset, state_ff.sticky != qtpd_pkg::ST_OK, state_ff.phase == qtpd_pkg::PH_HALT, "error without halt")
   `QTPD_ASSERT_NEXT(a_close_clears, clock, reset, take && req_item.end_of_list, state_ff.phase == qtpd_pkg::PH_ID && state_ff.seen == 17'd0, "list not cleared after close")
   `QTPD_ASSERT_SAME(a_last_is_verdict, clock, reset, rsp_valid && rsp_item.run_last, rsp_item.result_kind == qtpd_pkg::KIND_VERDICT, "run_last on non-verdict")

endmodule

@@ tb/tb.sv @@
// Self-checking bench for quic_transport_param_decoder: random and hand-built
// parameter lists against a built-in decoder predictor. Depends on qtpd_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qtpd_pkg::*;

   localparam logic [63:0] MASK62  = (64'd1 << 62) - 1;
   localparam logic [63:0] LEN_MAX = (64'd1 << 16) - 1;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          LONG_HOLD = 300;
   localparam int          BYTES_PER_PHASE = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_peer_is_server = 1'b0;

   quic_transport_param_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_peer_is_server(csr_peer_is_server)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   req_type   list_q[$];
   rsp_type   decoded_q[$];
   int        send_idle = 0;
   int        recv_stall = 0;
   int        hold_requests = 0;
   int        hold_served = 0;
   int        hold_left = 0;
   int        mismatches = 0;
   int        quiet_cycles = 0;
   int        bytes_made = 0;
   logic      req_fire = 1'b0;
   logic      csr_fire = 1'b0;

   // predictor state
   logic        peer_server;
   phase_type   phase;
   logic [63:0] accum;
   logic [2:0]  left;
   logic [4:0]  cur_id;
   logic        unk;
   logic [63:0] vlen;
   logic [63:0] vseen;
   logic [31:0] seen;
   logic [3:0]  sticky;
   logic [7:0]  pref_cid;

   task automatic clear_list();
      phase = PH_ID; accum = 0; left = 0; cur_id = 0; unk = 0;
      vlen = 0; vseen = 0; seen = 0; sticky = ST_OK; pref_cid = 0;
   endtask

   task automatic emit(logic [1:0] kind, logic [4:0] id, logic [63:0] v,
                       logic [7:0] bb, logic [63:0] bi, logic [3:0] st, logic last);
      rsp_type r;
      r.result_kind = kind; r.param_id = id; r.int_value = v[61:0];
      r.blob_byte = bb; r.blob_index = bi[4:0]; r.status = st; r.run_last = last;
      decoded_q.push_back(r);
   endtask

   task automatic halt(logic [3:0] st);
      sticky = st;
      phase = PH_HALT;
   endtask

   function automatic logic is_cid(logic [4:0] id);
      return id == ID_ORIG_DCID || id == ID_INIT_SCID || id == ID_RETRY_SCID;
   endfunction

   task automatic finish_param();
      logic [4:0]  id;
      logic [63:0] len;
      logic [63:0] v;
      id = cur_id;
      len = vlen;
      phase = PH_ID;
      if (unk) begin
         left = 0;
         return;
      end
      if (seen[id]) begin
         halt(ST_DUPLICATE);
         return;
      end
      seen[id] = 1'b1;
      if (!peer_server && (id == ID_ORIG_DCID || id == ID_RETRY_SCID ||
                           id == ID_RESET_TOKEN || id == ID_PREF_ADDR)) begin
         halt(ST_CLIENT_BAN);
         return;
      end
      if (is_cid(id)) begin
         if (len > MAX_CID_BYTES) begin
            halt(ST_CID_LEN);
            return;
         end
         emit(KIND_DONE, id, len, 0, 0, ST_OK, 0);
      end else if (id == ID_RESET_TOKEN) begin
         if (len != TOKEN_BYTES) begin
            halt(ST_TOKEN_LEN);
            return;
         end
         emit(KIND_DONE, id, len, 0, 0, ST_OK, 0);
      end else if (id == ID_NO_MIGRATE) begin
         if (len != 0) begin
            halt(ST_FLAG_LEN);
            return;
         end
         emit(KIND_DONE, id, 0, 0, 0, ST_OK, 0);
      end else if (id == ID_PREF_ADDR) begin
         if (len < PREF_FIXED || len != PREF_FIXED + pref_cid + TOKEN_BYTES ||
             pref_cid > MAX_CID_BYTES) begin
            halt(ST_PREF_ADDR);
            return;
         end
         emit(KIND_DONE, id, len, 0, 0, ST_OK, 0);
      end else begin
         if (len == 0 || len != (64'd1 << left[1:0])) begin
            halt(ST_INT_FILL);
            return;
         end
         v = accum & MASK62;
         if ((id == ID_MAX_UDP && v < UDP_MIN) ||
             ((id == ID_STREAMS_BIDI || id == ID_STREAMS_UNI) && v > STREAMS_MAX) ||
             (id == ID_ACK_EXP && v > ACK_EXP_MAX) ||
             (id == ID_ACK_DELAY && v >= ACK_DELAY_LIMIT) ||
             (id == ID_CID_LIMIT && v < CID_LIMIT_MIN)) begin
            halt(ST_RANGE);
            return;
         end
         emit(KIND_INT, id, v, 0, 0, ST_OK, 0);
      end
      left = 0;
   endtask

   task automatic decode_byte(logic [7:0] b);
      logic [63:0] idx;
      if (phase == PH_ID || phase == PH_LEN) begin
         if (left == 0) begin
            accum = {58'd0, b[5:0]};
            left = 3'((4'd1 << b[7:6]) - 1);
         end else begin
            accum = ((accum << 8) | b) & MASK62;
            left = left - 1;
         end
         if (left != 0) return;
         if (phase == PH_ID) begin
            unk = accum > 16;
            cur_id = unk ? 5'd0 : accum[4:0];
            phase = PH_LEN;
            return;
         end
         if (accum > LEN_MAX) begin
            halt(ST_TRUNCATED);
            return;
         end
         vlen = accum; vseen = 0; accum = 0; pref_cid = 0;
         if (vlen == 0) finish_param();
         else phase = PH_VAL;
         return;
      end
      if (phase != PH_VAL) return;
      idx = vseen;
      if (!unk) begin
         if (is_cid(cur_id)) begin
            if (vlen <= MAX_CID_BYTES) emit(KIND_BLOB, cur_id, 0, b, idx, ST_OK, 0);
         end else if (cur_id == ID_RESET_TOKEN) begin
            if (vlen == TOKEN_BYTES) emit(KIND_BLOB, cur_id, 0, b, idx, ST_OK, 0);
         end else if (cur_id == ID_PREF_ADDR) begin
            if (idx == PREF_CID_POS) pref_cid = b;
         end else if (cur_id != ID_NO_MIGRATE) begin
            if (idx == 0) begin
               left = {1'b0, b[7:6]};
               accum = {58'd0, b[5:0]};
            end else if (idx < (64'd1 << left[1:0])) begin
               accum = ((accum << 8) | b) & MASK62;
            end
         end
      end
      vseen = idx + 1;
      if (vseen >= vlen) finish_param();
   endtask

   task automatic close_list();
      logic [3:0] st;
      if (sticky != ST_OK) st = sticky;
      else if (phase != PH_ID || left != 0) st = ST_TRUNCATED;
      else if (!seen[ID_INIT_SCID]) st = ST_NO_INIT_SCID;
      else if (peer_server && !seen[ID_ORIG_DCID]) st = ST_NO_ORIG_DCID;
      else st = ST_OK;
      emit(KIND_VERDICT, 0, 0, 0, 0, st, 1);
      clear_list();
   endtask

   // compare outgoing beats first, then advance the predictor on incoming ones
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      csr_fire <= !reset && csr_valid && csr_ready;
      if (reset) begin
         peer_server = 1'b0;
         clear_list();
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_item);
            end else begin
               if (rsp_item.result_kind !== decoded_q[0].result_kind ||
                   rsp_item.param_id !== decoded_q[0].param_id ||
                   rsp_item.int_value !== decoded_q[0].int_value ||
                   rsp_item.blob_byte !== decoded_q[0].blob_byte ||
                   rsp_item.blob_index !== decoded_q[0].blob_index ||
                   rsp_item.status !== decoded_q[0].status ||
                   rsp_item.run_last !== decoded_q[0].run_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p got %p", decoded_q[0], rsp_item);
               end
               void'(decoded_q.pop_front());
            end
         end
         if (csr_valid && csr_ready) peer_server = csr_peer_is_server;
         if (req_valid && req_ready) begin
            if (req_item.byte_present && phase != PH_HALT) decode_byte(req_item.list_byte);
            if (req_item.end_of_list) close_list();
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // sender: hold the beat until taken, then advance or idle
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (list_q.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_valid <= 1'b1;
            req_item <= list_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_served <= hold_served + 1;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic put(logic [7:0] b, logic present = 1'b1, logic last = 1'b0);
      req_type r;
      r.list_byte = b; r.byte_present = present; r.end_of_list = last;
      list_q.push_back(r);
      if (present) bytes_made++;
   endtask

   function automatic int min_class(logic [63:0] v);
      if (v < 64) return 0;
      if (v < 16384) return 1;
      if (v < (64'd1 << 30)) return 2;
      return 3;
   endfunction

   task automatic put_varint(logic [63:0] v, int cls);
      int n;
      logic [7:0] b;
      n = 1 << cls;
      for (int i = n - 1; i >= 0; i--) begin
         b = v[8*i +: 8];
         if (i == n - 1) b = {2'(cls), b[5:0]};
         put(b);
      end
   endtask

   task automatic put_int(logic [4:0] id, logic [63:0] v, logic bad_fill);
      int cls;
      cls = min_class(v);
      if (cls < 3 && $urandom_range(3) == 0) cls = $urandom_range(cls, 3);
      put_varint(64'(id), $urandom_range(1));
      put_varint(64'((1 << cls) + (bad_fill ? 1 : 0)), 0);
      put_varint(v, cls);
      if (bad_fill) put(8'($urandom_range(255)));
   endtask

   task automatic put_blob(logic [4:0] id, int n);
      put_varint(64'(id), 0);
      put_varint(64'(n), 0);
      repeat (n) put(8'($urandom_range(255)));
   endtask

   task automatic put_pref(int cid_len, logic bad_len);
      put_varint(64'(ID_PREF_ADDR), 0);
      put_varint(64'(bad_len ? 25 + cid_len + $urandom_range(15) : 41 + cid_len), 0);
      repeat (24) put(8'($urandom_range(255)));
      put(8'(cid_len));
      repeat (cid_len + (bad_len ? 0 : 16)) put(8'($urandom_range(255)));
   endtask

   function automatic logic [63:0] good_value(logic [4:0] id);
      case (id)
         ID_MAX_UDP:      return $urandom_range(65527, 1200);
         ID_STREAMS_BIDI,
         ID_STREAMS_UNI:  return $urandom_range(1) ? STREAMS_MAX : $urandom_range(1000);
         ID_ACK_EXP:      return $urandom_range(20);
         ID_ACK_DELAY:    return $urandom_range(16383);
         ID_CID_LIMIT:    return $urandom_range(200, 2);
         default:         return {$urandom, $urandom} & MASK62 >> (2 * $urandom_range(30));
      endcase
   endfunction

   task automatic put_param(logic [4:0] id, logic broken);
      if (is_cid(id)) begin
         put_blob(id, broken ? $urandom_range(30, 21) : $urandom_range(20));
      end else if (id == ID_RESET_TOKEN) begin
         put_blob(id, broken ? 15 : 16);
      end else if (id == ID_NO_MIGRATE) begin
         put_blob(id, broken ? 1 : 0);
      end else if (id == ID_PREF_ADDR) begin
         put_pref(broken ? $urandom_range(1) * 21 : $urandom_range(20),
                  broken && $urandom_range(1));
      end else if (broken && $urandom_range(1)) begin
         put_int(id, good_value(id), 1'b1);
      end else begin
         put_int(id, broken ? {$urandom, $urandom} & MASK62 : good_value(id), 1'b0);
      end
   endtask

   task automatic make_list();
      logic [16:0] used;
      int          n;
      int          id;
      logic        noisy;
      int          start;
      used = 0;
      noisy = $urandom_range(9) < 2;
      n = $urandom_range(5, 1);
      for (int i = 0; i < n; i++) begin
         id = $urandom_range(17);
         if (id == 17) begin
            put_varint(64'($urandom_range(1000, 17)), $urandom_range(1, 2));
            start = $urandom_range(4);
            put_varint(64'(start), 0);
            repeat (start) put(8'($urandom_range(255)));
            continue;
         end
         if (used[id] && $urandom_range(7) != 0) continue;
         if (!peer_server && (id == ID_ORIG_DCID || id == ID_RETRY_SCID ||
             id == ID_RESET_TOKEN || id == ID_PREF_ADDR) && $urandom_range(7) != 0)
            continue;
         used[id] = 1'b1;
         put_param(5'(id), $urandom_range(19) == 0);
         if (noisy) put(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      if (csr_peer_is_server && !used[ID_ORIG_DCID] && $urandom_range(4) != 0)
         put_param(ID_ORIG_DCID, 1'b0);
      if (!used[ID_INIT_SCID] && $urandom_range(9) != 0) put_param(ID_INIT_SCID, 1'b0);
      // drop the tail of the odd list to end mid-parameter
      if (noisy && list_q.size() > 2 && $urandom_range(1))
         repeat ($urandom_range(2, 1)) void'(list_q.pop_back());
      if (list_q.size() != 0 && list_q[$].byte_present && !list_q[$].end_of_list &&
          $urandom_range(1))
         list_q[$].end_of_list = 1'b1;
      else
         put(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic drain();
      while (list_q.size() != 0 || req_valid || decoded_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_server(logic v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_peer_is_server <= v;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(int idle, int stall, logic server, logic long_hold);
      int goal;
      send_idle = idle;
      recv_stall = stall;
      write_server(server);
      if (long_hold) hold_requests++;
      goal = bytes_made + BYTES_PER_PHASE;
      while (bytes_made < goal) make_list();
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // hand-built lists: empty close, idle beat, three results from one beat,
      // widest integer, too-small udp payload size, forbidden client id, oversized length, skipped id
      put(8'hff, 1'b0, 1'b1);
      put(8'hff, 1'b0, 1'b0);
      put(8'(ID_INIT_SCID)); put(8'd1); put(8'hab, 1'b1, 1'b1);
      put_int(5'd4, MASK62, 1'b0);
      put_int(ID_MAX_UDP, 64'd1199, 1'b0);
      put(8'h00, 1'b0, 1'b1);
      put(8'(ID_ORIG_DCID)); put(8'd0); put(8'h00, 1'b0, 1'b1);
      put(8'(ID_INIT_SCID)); put(8'h80); put(8'h01); put(8'h00); put(8'h00);
      put(8'h00, 1'b0, 1'b1);
      put(8'h40); put(8'h11); put(8'd1); put(8'h00);
      put(8'(ID_INIT_SCID)); put(8'd0, 1'b1, 1'b1);
      drain();
      run_phase(0, 0, 1'b0, 1'b1);
      run_phase(82, 0, 1'b1, 1'b0);
      run_phase(0, 82, 1'b0, 1'b0);
      run_phase(20, 20, 1'b1, 1'b1);
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
